// ===== hw/rtl/interval_merge_filter_defines.svh =====
// Assertion helpers used by the interval merge filter datapath.
`ifndef INTERVAL_MERGE_FILTER_DEFINES_SVH
`define INTERVAL_MERGE_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IMF_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval merge filter check failed");

// Next-cycle implication, disabled while reset is high.
`define IMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval merge filter check failed");

`endif

// ===== hw/rtl/imf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imf_pkg;

  // Fixed widths of the channel fields and of the configuration port.
  localparam int unsigned FIELD_W   = 32;
  localparam int unsigned MIN_DUR_W = 17;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;
  localparam int unsigned REG_IDX_W = 1;

  // Register indexes (byte address is 4 times the index).
  localparam logic [REG_IDX_W-1:0] REG_DETECT_ENABLE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_DURATION  = 1'b1;

  // Reset values of the registers.
  localparam logic                 DETECT_ENABLE_RST = 1'b1;
  localparam logic [MIN_DUR_W-1:0] MIN_DURATION_RST  = 17'd300;

  // Item opcodes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [FIELD_W-1:0] period_start;
    logic [FIELD_W-1:0] period_end;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] entry_start;
    logic [FIELD_W-1:0] entry_end;
    logic               entry_valid;
    logic               last_entry;
    logic               idle_found;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_FLUSH,
    ST_COMMIT,
    ST_EMIT
  } imf_state_t;

  typedef struct packed {
    logic capture;
    logic merge_step;
    logic flush;
    logic commit;
    logic emit_step;
  } imf_cmd_t;

  typedef struct packed {
    logic start_merge;
    logic merge_done;
    logic out_free;
    logic emit_last;
  } imf_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/interval_merge_filter.sv =====
// Interval merge filter: keeps a sorted, merged table of time intervals.
// Item channel (item_valid / item_stall / item): a transaction carries either
// an insert of one interval or a clear of the whole table. Result channel
// (result_valid / result_stall / result): after every item the block sends
// one transaction per stored entry, in order, the final one marked with
// last_entry; an empty table gives a single transaction with entry_valid low.
// The block works on one item at a time. An insert with detection enabled
// walks the old table once through a single memory read port to merge it
// with the new interval, and then walks the new table once to send it. A
// clear or a disabled insert only sends the table.
// The next item is taken while the last result still sits in the output
// register; a stalled result holds there and simply delays the next table
// walk. Reset empties the table and loads detect_enable = 1 and
// min_duration = 300; the table memory itself needs no clearing pass.
// Registers (APB, byte address 4 * index): detect_enable at 0x0,
// min_duration at 0x4. Write them only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module interval_merge_filter #(
  parameter int unsigned MAX_PERIODS = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  imf_pkg::in_item_t             item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output imf_pkg::out_item_t            result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imf_pkg::APB_AW-1:0]    paddr,
  input  logic [imf_pkg::APB_DW-1:0]    pwdata,
  output logic [imf_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import imf_pkg::*;

  logic                 detect_enable;
  logic [MIN_DUR_W-1:0] min_duration;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_write;

  imf_cmd_t    cmd;
  imf_status_t status;

  // The APB port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[APB_AW-1:2];
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_enable <= DETECT_ENABLE_RST;
      min_duration  <= MIN_DURATION_RST;
    end else if (reg_write) begin
      unique case (reg_idx)
        REG_DETECT_ENABLE: detect_enable <= pwdata[0];
        REG_MIN_DURATION:  min_duration  <= pwdata[MIN_DUR_W-1:0];
        default:           detect_enable <= detect_enable;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DETECT_ENABLE: prdata = APB_DW'(detect_enable);
      REG_MIN_DURATION:  prdata = APB_DW'(min_duration);
      default:           prdata = '0;
    endcase
  end

  // The controller sequences capture, merge, flush, commit and send; the
  // datapath owns the table memory, the merge pipeline and the output register.
  imf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  imf_datapath #(
    .MAX_PERIODS (MAX_PERIODS),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .item          (item),
    .detect_enable (detect_enable),
    .min_duration  (min_duration),
    .result        (result),
    .result_valid  (result_valid),
    .result_stall  (result_stall)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/imf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module imf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  imf_pkg::imf_status_t status,
  output imf_pkg::imf_cmd_t    cmd
);
  import imf_pkg::*;

  imf_state_t state;
  imf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = status.start_merge ? ST_MERGE : ST_EMIT;
        end
      end
      ST_MERGE: begin
        if (status.merge_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall  = 1'b0;
        cmd.capture = item_valid;
      end
      ST_MERGE:  cmd.merge_step = 1'b1;
      ST_FLUSH:  cmd.flush      = 1'b1;
      ST_COMMIT: cmd.commit     = 1'b1;
      ST_EMIT:   cmd.emit_step  = status.out_free;
      default:   cmd            = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/imf_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "interval_merge_filter_defines.svh"

module imf_datapath #(
  parameter int unsigned MAX_PERIODS = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  imf_pkg::imf_cmd_t                cmd,
  output imf_pkg::imf_status_t             status,
  input  imf_pkg::in_item_t                item,
  input  logic                             detect_enable,
  input  logic [imf_pkg::MIN_DUR_W-1:0]    min_duration,
  output imf_pkg::out_item_t               result,
  output logic                             result_valid,
  input  logic                             result_stall
);
  import imf_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_PERIODS + 1);
  localparam int unsigned AW    = $clog2(MAX_PERIODS);
  localparam int unsigned DEPTH = 2 ** (AW + 1);
  localparam int unsigned DW    = (TIME_BITS > MIN_DUR_W) ? TIME_BITS : MIN_DUR_W;

  // Two banks in one memory: the live table and the one being rebuilt.
  logic [2*TIME_BITS-1:0] mem [0:DEPTH-1];
  logic [2*TIME_BITS-1:0] rdata;
  logic [AW:0]            raddr;
  logic [AW:0]            waddr;
  logic                   we;

  logic                 bank;
  logic                 bank_next;
  logic [CW-1:0]        count;
  logic [CW-1:0]        rd;
  logic [CW-1:0]        rd_next;
  logic [CW-1:0]        kept;
  logic                 new_used;
  logic [TIME_BITS-1:0] new_s;
  logic [TIME_BITS-1:0] new_e;
  logic                 x_valid;
  logic [TIME_BITS-1:0] x_s;
  logic [TIME_BITS-1:0] x_e;
  logic                 cur_valid;
  logic [TIME_BITS-1:0] cur_s;
  logic [TIME_BITS-1:0] cur_e;
  logic                 item_ovf;
  logic                 item_idle;

  logic [TIME_BITS-1:0] rd_s;
  logic [TIME_BITS-1:0] rd_e;
  logic [TIME_BITS-1:0] diff;
  logic [63:0]          in_s64;
  logic [63:0]          in_e64;
  logic [63:0]          out_s64;
  logic [63:0]          out_e64;
  logic                 remaining;
  logic                 take_new;
  logic                 pick;
  logic                 x_joins;
  logic                 close_en;
  logic                 close_keep;
  logic                 kept_full;
  logic                 close_wr;
  logic                 out_free;
  logic                 emit_last;

  assign rd_s = rdata[2*TIME_BITS-1:TIME_BITS];
  assign rd_e = rdata[TIME_BITS-1:0];

  assign in_s64  = 64'(item.period_start);
  assign in_e64  = 64'(item.period_end);
  assign out_s64 = 64'(rd_s);
  assign out_e64 = 64'(rd_e);

  // Pick stage: the next element in (start, end) order from the stored
  // table and the new interval; ties keep the stored entry first.
  assign remaining = (rd < count) || !new_used;
  assign take_new  = !new_used &&
                     ((rd == count) || (new_s < rd_s) || ((new_s == rd_s) && (new_e < rd_e)));
  assign pick      = cmd.merge_step && remaining;

  // Merge stage: extend the open group or close it.
  assign x_joins    = (x_s >= cur_s) && (x_s <= cur_e);
  assign close_en   = (cmd.merge_step && x_valid && cur_valid && !x_joins) || cmd.flush;
  assign diff       = cur_e - cur_s;
  assign close_keep = (cur_e >= cur_s) && (DW'(diff) >= DW'(min_duration));
  assign kept_full  = kept >= CW'(MAX_PERIODS);
  assign close_wr   = close_en && close_keep && !kept_full;

  assign we    = close_wr;
  assign waddr = {~bank, kept[AW-1:0]};

  assign out_free  = !result_valid || !result_stall;
  assign emit_last = (count == '0) || (rd == count - CW'(1));

  assign status.start_merge = (item.opcode == OP_INSERT) && detect_enable;
  assign status.merge_done  = !remaining && !x_valid;
  assign status.out_free    = out_free;
  assign status.emit_last   = emit_last;

  always_comb begin
    bank_next = cmd.commit ? ~bank : bank;
    rd_next   = rd;
    if (cmd.capture || cmd.commit) begin
      rd_next = '0;
    end else if (pick && !take_new) begin
      rd_next = rd + CW'(1);
    end else if (cmd.emit_step) begin
      rd_next = emit_last ? '0 : rd + CW'(1);
    end
  end

  // The read address follows the next read pointer, so rdata always holds
  // the entry at the current pointer of the live bank.
  assign raddr = {bank_next, rd_next[AW-1:0]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {cur_s, cur_e};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank         <= 1'b0;
      count        <= '0;
      rd           <= '0;
      kept         <= '0;
      new_used     <= 1'b0;
      x_valid      <= 1'b0;
      cur_valid    <= 1'b0;
      item_ovf     <= 1'b0;
      item_idle    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      bank <= bank_next;
      rd   <= rd_next;
      if (cmd.capture) begin
        new_used  <= 1'b0;
        x_valid   <= 1'b0;
        cur_valid <= 1'b0;
        kept      <= '0;
        item_ovf  <= 1'b0;
        item_idle <= 1'b0;
        if (item.opcode == OP_CLEAR) begin
          count <= '0;
        end
      end
      if (cmd.merge_step) begin
        x_valid <= pick;
        if (pick && take_new) begin
          new_used <= 1'b1;
        end
        if (x_valid) begin
          cur_valid <= 1'b1;
        end
      end
      if (close_wr) begin
        kept <= kept + CW'(1);
      end
      if (close_en && close_keep && kept_full) begin
        item_ovf <= 1'b1;
      end
      if (cmd.commit) begin
        count     <= kept;
        item_idle <= kept != '0;
      end
      if (cmd.emit_step) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      new_s <= in_s64[TIME_BITS-1:0];
      new_e <= in_e64[TIME_BITS-1:0];
    end
    if (pick) begin
      x_s <= take_new ? new_s : rd_s;
      x_e <= take_new ? new_e : rd_e;
    end
    if (cmd.merge_step && x_valid) begin
      if (!cur_valid || !x_joins) begin
        cur_s <= x_s;
        cur_e <= x_e;
      end else if (x_e > cur_e) begin
        cur_e <= x_e;
      end
    end
    if (cmd.emit_step) begin
      if (count == '0) begin
        result.entry_start <= '0;
        result.entry_end   <= '0;
        result.entry_valid <= 1'b0;
        result.last_entry  <= 1'b1;
        result.idle_found  <= 1'b0;
        result.overflow    <= 1'b0;
      end else begin
        result.entry_start <= out_s64[FIELD_W-1:0];
        result.entry_end   <= out_e64[FIELD_W-1:0];
        result.entry_valid <= 1'b1;
        result.last_entry  <= emit_last;
        result.idle_found  <= item_idle;
        result.overflow    <= item_ovf;
      end
    end
  end

  `IMF_ASSERT_IMPL(a_kept_bound, clk, rst, cmd.merge_step || cmd.flush, kept <= CW'(MAX_PERIODS))
  `IMF_ASSERT_NEXT(a_commit_count, clk, rst, cmd.commit, count == $past(kept))
  `IMF_ASSERT_NEXT(a_emit_wrap, clk, rst, cmd.emit_step && emit_last, rd == '0)
  `IMF_ASSERT_IMPL(a_ovf_full, clk, rst, item_ovf, kept == CW'(MAX_PERIODS))

endmodule

`default_nettype wire
